@@ src/fwd_pkg.sv @@
// shared types, codes and defaults of the firmware update deframer
package fwd_pkg;

  localparam int PAGE_BYTES_DEF = 1024;
  localparam int WORD_BYTES_DEF = 4;
  localparam int IV_BYTES_DEF   = 16;
  localparam int TAG_BYTES_DEF  = 32;

  localparam int ADDR_W = 18;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 11;
  localparam int VER_W  = 16;
  localparam int EV_W   = 3;
  localparam int CFG_W  = 18;

  localparam logic [ADDR_W-1:0] IMAGE_BASE_RST = 18'h10000;

  localparam logic [BYTE_W-1:0] CMD_UPDATE = 8'h55;
  localparam logic [BYTE_W-1:0] CMD_BOOT   = 8'h42;

  localparam logic [0:0] CFG_STORED_VERSION = 1'b0;
  localparam logic [0:0] CFG_IMAGE_BASE     = 1'b1;

  localparam logic [EV_W-1:0] EV_ECHO     = 3'd0;
  localparam logic [EV_W-1:0] EV_BOOT     = 3'd1;
  localparam logic [EV_W-1:0] EV_META_OK  = 3'd2;
  localparam logic [EV_W-1:0] EV_META_REJ = 3'd3;
  localparam logic [EV_W-1:0] EV_WRITE    = 3'd4;
  localparam logic [EV_W-1:0] EV_COMMIT   = 3'd5;
  localparam logic [EV_W-1:0] EV_ACK      = 3'd6;
  localparam logic [EV_W-1:0] EV_DROP     = 3'd7;

  typedef struct packed {
    logic [EV_W-1:0]   event_res;
    logic [ADDR_W-1:0] flash_address;
    logic [BYTE_W-1:0] write_byte;
    logic [CNT_W-1:0]  page_bytes;
    logic [CNT_W-1:0]  padded_bytes;
    logic [VER_W-1:0]  meta_version;
    logic [VER_W-1:0]  meta_size;
    logic              last;
  } result_t;

endpackage

@@ src/fwd_parse.sv @@
// byte parser: command, metadata, frame and trailer tracking, result generation
module fwd_parse import fwd_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int WORD_BYTES = WORD_BYTES_DEF,
  parameter int IV_BYTES   = IV_BYTES_DEF,
  parameter int TAG_BYTES  = TAG_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic [1:0]        push_cnt,
  output result_t           res0,
  output result_t           res1
);

  localparam int FILL_W    = $clog2(PAGE_BYTES + 1);
  localparam int WPH_W     = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int PAD_W     = FILL_W + 4;
  localparam int TRAIL_LEN = ((IV_BYTES + TAG_BYTES) > 0) ? (IV_BYTES + TAG_BYTES) : 1;

  localparam logic [3:0] PH_CMD         = 4'd0;
  localparam logic [3:0] PH_VER_LO      = 4'd1;
  localparam logic [3:0] PH_VER_HI      = 4'd2;
  localparam logic [3:0] PH_SIZE_LO     = 4'd3;
  localparam logic [3:0] PH_SIZE_HI     = 4'd4;
  localparam logic [3:0] PH_LEN_HI      = 4'd5;
  localparam logic [3:0] PH_LEN_LO      = 4'd6;
  localparam logic [3:0] PH_DATA        = 4'd7;
  localparam logic [3:0] PH_FRAME_TRAIL = 4'd8;
  localparam logic [3:0] PH_END_TRAIL   = 4'd9;

  logic [3:0]        phase_r, phase_nxt;
  logic [VER_W-1:0]  new_version_r, new_version_nxt;
  logic [VER_W-1:0]  image_size_r, image_size_nxt;
  logic [15:0]       frame_len_r, frame_len_nxt;
  logic [15:0]       seg_count_r, seg_count_nxt;
  logic [FILL_W-1:0] page_fill_r, page_fill_nxt;
  logic [WPH_W-1:0]  word_phase_r, word_phase_nxt;
  logic [ADDR_W-1:0] page_base_r, page_base_nxt;
  logic [VER_W-1:0]  stored_version_r;
  logic [ADDR_W-1:0] image_base_r;

  logic [15:0]       seg_inc;
  logic [VER_W-1:0]  size_full;
  logic [15:0]       len_full;
  logic [PAD_W-1:0]  pad_sum;
  logic              page_full;

  assign seg_inc   = seg_count_r + 16'd1;
  assign size_full = {rx_byte, image_size_r[7:0]};
  assign len_full  = {frame_len_r[15:8], rx_byte};
  assign page_full = (page_fill_r >= FILL_W'(PAGE_BYTES));
  // word_phase tracks fill mod word size, so rounding up needs no divider
  assign pad_sum   = PAD_W'(page_fill_r) +
                     ((word_phase_r == '0) ? PAD_W'(0)
                                           : (PAD_W'(WORD_BYTES) - PAD_W'(word_phase_r)));

  always_comb begin
    phase_nxt       = phase_r;
    new_version_nxt = new_version_r;
    image_size_nxt  = image_size_r;
    frame_len_nxt   = frame_len_r;
    seg_count_nxt   = seg_count_r;
    page_fill_nxt   = page_fill_r;
    word_phase_nxt  = word_phase_r;
    page_base_nxt   = page_base_r;
    push_cnt        = 2'd0;
    res0            = '0;
    res1            = '0;
    if (accept) begin
      unique case (phase_r)
        PH_CMD: begin
          if (rx_byte == CMD_UPDATE) begin
            res0.event_res = EV_ECHO;
            res0.last      = 1'b1;
            push_cnt       = 2'd1;
            phase_nxt      = PH_VER_LO;
          end else if (rx_byte == CMD_BOOT) begin
            res0.event_res = EV_BOOT;
            res0.last      = 1'b1;
            push_cnt       = 2'd1;
          end
        end
        PH_VER_LO: begin
          new_version_nxt = {8'h00, rx_byte};
          phase_nxt       = PH_VER_HI;
        end
        PH_VER_HI: begin
          new_version_nxt = {rx_byte, new_version_r[7:0]};
          phase_nxt       = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          image_size_nxt = {8'h00, rx_byte};
          phase_nxt      = PH_SIZE_HI;
        end
        PH_SIZE_HI: begin
          image_size_nxt = size_full;
          res0.last      = 1'b1;
          push_cnt       = 2'd1;
          if (new_version_r != '0 && new_version_r < stored_version_r) begin
            res0.event_res = EV_META_REJ;
            phase_nxt      = PH_CMD;
          end else begin
            // version zero keeps the stored one
            new_version_nxt   = (new_version_r == '0) ? stored_version_r : new_version_r;
            res0.event_res    = EV_META_OK;
            res0.meta_version = (new_version_r == '0) ? stored_version_r : new_version_r;
            res0.meta_size    = size_full;
            page_base_nxt     = image_base_r;
            page_fill_nxt     = '0;
            word_phase_nxt    = '0;
            phase_nxt         = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          frame_len_nxt = {rx_byte, 8'h00};
          phase_nxt     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len_nxt = len_full;
          seg_count_nxt = '0;
          phase_nxt     = (len_full != '0) ? PH_DATA : PH_FRAME_TRAIL;
        end
        PH_DATA: begin
          res0.last = 1'b1;
          push_cnt  = 2'd1;
          if (!page_full) begin
            res0.event_res     = EV_WRITE;
            res0.flash_address = page_base_r + ADDR_W'(page_fill_r);
            res0.write_byte    = rx_byte;
            page_fill_nxt      = page_fill_r + FILL_W'(1);
            word_phase_nxt     = (word_phase_r == WPH_W'(WORD_BYTES - 1)) ? '0
                                                                           : word_phase_r + WPH_W'(1);
          end else begin
            res0.event_res = EV_DROP;
          end
          if (seg_inc >= frame_len_r) begin
            seg_count_nxt = '0;
            phase_nxt     = PH_FRAME_TRAIL;
          end else begin
            seg_count_nxt = seg_inc;
          end
        end
        PH_FRAME_TRAIL: begin
          if (seg_inc >= 16'(TRAIL_LEN)) begin
            seg_count_nxt = '0;
            if (page_full || frame_len_r == '0) begin
              res0.event_res     = EV_COMMIT;
              res0.flash_address = page_base_r;
              res0.page_bytes    = CNT_W'(page_fill_r);
              res0.padded_bytes  = CNT_W'(pad_sum);
              res1.event_res     = EV_ACK;
              res1.last          = 1'b1;
              push_cnt           = 2'd2;
              page_base_nxt      = page_base_r + ADDR_W'(PAGE_BYTES);
              page_fill_nxt      = '0;
              word_phase_nxt     = '0;
            end else begin
              res0.event_res = EV_ACK;
              res0.last      = 1'b1;
              push_cnt       = 2'd1;
            end
            phase_nxt = (frame_len_r == '0) ? PH_END_TRAIL : PH_LEN_HI;
          end else begin
            seg_count_nxt = seg_inc;
          end
        end
        PH_END_TRAIL: begin
          if (seg_inc >= 16'(TRAIL_LEN)) begin
            seg_count_nxt = '0;
            phase_nxt     = PH_CMD;
          end else begin
            seg_count_nxt = seg_inc;
          end
        end
        default: begin
          phase_nxt = PH_CMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_CMD;
      new_version_r <= '0;
      image_size_r  <= '0;
      frame_len_r   <= '0;
      seg_count_r   <= '0;
      page_fill_r   <= '0;
      word_phase_r  <= '0;
      page_base_r   <= IMAGE_BASE_RST;
    end else begin
      phase_r       <= phase_nxt;
      new_version_r <= new_version_nxt;
      image_size_r  <= image_size_nxt;
      frame_len_r   <= frame_len_nxt;
      seg_count_r   <= seg_count_nxt;
      page_fill_r   <= page_fill_nxt;
      word_phase_r  <= word_phase_nxt;
      page_base_r   <= page_base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_version_r <= '0;
      image_base_r     <= IMAGE_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STORED_VERSION: stored_version_r <= cfg_wdata[VER_W-1:0];
        CFG_IMAGE_BASE:     image_base_r     <= cfg_wdata[ADDR_W-1:0];
        default:            stored_version_r <= stored_version_r;
      endcase
    end
  end

endmodule

@@ src/fwd_outq.sv @@
// four-entry result queue taking up to two results per cycle, one out per cycle while out_ready is high
module fwd_outq import fwd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    res0,
  input  result_t    res1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_QW = $clog2(DEPTH + 1);

  result_t             q_r [DEPTH];
  logic [PTR_W-1:0]    wr_r, wr_nxt;
  logic [PTR_W-1:0]    rd_r, rd_nxt;
  logic [CNT_QW-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]    wr_plus1;
  logic                pop;

  assign out_valid = (count_r != '0);
  assign out_res   = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  // two free slots, so a byte that ends a frame always fits
  assign room      = (count_r <= CNT_QW'(DEPTH - 2));
  assign wr_plus1  = wr_r + PTR_W'(1);

  always_comb begin
    wr_nxt    = wr_r + PTR_W'(push_cnt);
    rd_nxt    = pop ? rd_r + PTR_W'(1) : rd_r;
    count_nxt = count_r + CNT_QW'(push_cnt) - CNT_QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wr_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wr_plus1] <= res1;
    end
  end

endmodule

@@ src/firmware_update_deframer_top.sv @@
// top level of the firmware update deframer
// Takes one link byte per cycle while in_ready is high and decodes update commands,
// metadata and data frames into flash write, page commit and status results. Each
// accepted byte is decoded in the cycle it is taken and its results (at most two, only
// a frame end with a page commit gives two) go into a four-entry result queue that
// delivers one result per cycle while out_ready is high. The input is ready while the
// queue has two free entries, so with a free-running sink a byte is taken every cycle;
// a result shows in the cycle after its byte, an ack after its commit. Configuration
// writes are taken at any time and should be made while no byte is in flight.
module firmware_update_deframer_top import fwd_pkg::*; #(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF,
  parameter int WORD_BYTES = WORD_BYTES_DEF,
  parameter int IV_BYTES   = IV_BYTES_DEF,
  parameter int TAG_BYTES  = TAG_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EV_W-1:0]   out_event_res,
  output logic [ADDR_W-1:0] out_flash_address,
  output logic [BYTE_W-1:0] out_write_byte,
  output logic [CNT_W-1:0]  out_page_bytes,
  output logic [CNT_W-1:0]  out_padded_bytes,
  output logic [VER_W-1:0]  out_meta_version,
  output logic [VER_W-1:0]  out_meta_size,
  output logic              out_last
);

  logic       room;
  logic       accept;
  logic [1:0] push_cnt;
  result_t    res0;
  result_t    res1;
  result_t    out_res;

  assign in_ready = room;
  assign accept   = in_valid && room;

  fwd_parse #(
    .PAGE_BYTES (PAGE_BYTES),
    .WORD_BYTES (WORD_BYTES),
    .IV_BYTES   (IV_BYTES),
    .TAG_BYTES  (TAG_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  fwd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_res     = out_res.event_res;
  assign out_flash_address = out_res.flash_address;
  assign out_write_byte    = out_res.write_byte;
  assign out_page_bytes    = out_res.page_bytes;
  assign out_padded_bytes  = out_res.padded_bytes;
  assign out_meta_version  = out_res.meta_version;
  assign out_meta_size     = out_res.meta_size;
  assign out_last          = out_res.last;

endmodule

@@ dv/firmware_update_deframer_top_tb.sv @@
// testbench for the firmware update deframer: byte stimulus, result prediction and checking
module firmware_update_deframer_top_tb import fwd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRAILER_BYTES =
    (IV_BYTES_DEF + TAG_BYTES_DEF > 0) ? IV_BYTES_DEF + TAG_BYTES_DEF : 1;
  localparam int ITEM_TARGET = 1600;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic [3:0] {
    LP_COMMAND, LP_VER_LO, LP_VER_HI, LP_SIZE_LO, LP_SIZE_HI,
    LP_LEN_HI, LP_LEN_LO, LP_DATA, LP_FRAME_TRAIL, LP_END_TRAIL
  } link_phase_e;

  typedef enum logic [1:0] {ROW_MODEL, ROW_QUIET, ROW_TYPED} row_kind_e;

  typedef struct {
    logic [BYTE_W-1:0] rx;
    row_kind_e         kind;
    logic [EV_W-1:0]   ev;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = CFG_STORED_VERSION;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [EV_W-1:0]   out_event_res;
  logic [ADDR_W-1:0] out_flash_address;
  logic [BYTE_W-1:0] out_write_byte;
  logic [CNT_W-1:0]  out_page_bytes;
  logic [CNT_W-1:0]  out_padded_bytes;
  logic [VER_W-1:0]  out_meta_version;
  logic [VER_W-1:0]  out_meta_size;
  logic              out_last;

  // predictor copy of the registers and the deframer state
  logic [VER_W-1:0]  stored_version_cfg = '0;
  logic [ADDR_W-1:0] image_base_cfg = IMAGE_BASE_RST;
  link_phase_e       link_phase = LP_COMMAND;
  logic [VER_W-1:0]  pend_version = '0;
  logic [VER_W-1:0]  pend_size = '0;
  logic [15:0]       frame_size = '0;
  int                byte_count = 0;
  int                page_fill = 0;
  logic [ADDR_W-1:0] page_base = IMAGE_BASE_RST;

  result_t     expected_results[$];
  int          frame_plan[$];
  int          items_sent = 0;
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  // ev only matters on typed rows; stored version is 0xFFFF while these run
  stim_row_t directed_rows [0:21] = '{
    '{8'h00, ROW_QUIET, EV_ECHO},
    '{8'hFF, ROW_QUIET, EV_ECHO},
    '{8'h54, ROW_QUIET, EV_ECHO},
    '{8'h56, ROW_QUIET, EV_ECHO},
    '{8'h75, ROW_QUIET, EV_ECHO},
    '{CMD_BOOT, ROW_TYPED, EV_BOOT},
    '{CMD_BOOT, ROW_TYPED, EV_BOOT},
    '{CMD_UPDATE, ROW_TYPED, EV_ECHO},
    '{8'h01, ROW_QUIET, EV_ECHO},
    '{8'h00, ROW_QUIET, EV_ECHO},
    '{8'hFF, ROW_QUIET, EV_ECHO},
    '{8'hFF, ROW_TYPED, EV_META_REJ},
    '{CMD_UPDATE, ROW_TYPED, EV_ECHO},
    '{8'hFE, ROW_QUIET, EV_ECHO},
    '{8'hFF, ROW_QUIET, EV_ECHO},
    '{8'h00, ROW_QUIET, EV_ECHO},
    '{8'h00, ROW_TYPED, EV_META_REJ},
    // command codes inside metadata are plain data
    '{CMD_UPDATE, ROW_TYPED, EV_ECHO},
    '{CMD_UPDATE, ROW_QUIET, EV_ECHO},
    '{CMD_BOOT, ROW_QUIET, EV_ECHO},
    '{CMD_UPDATE, ROW_QUIET, EV_ECHO},
    '{CMD_BOOT, ROW_TYPED, EV_META_REJ}
  };

  firmware_update_deframer_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_res     (out_event_res),
    .out_flash_address (out_flash_address),
    .out_write_byte    (out_write_byte),
    .out_page_bytes    (out_page_bytes),
    .out_padded_bytes  (out_padded_bytes),
    .out_meta_version  (out_meta_version),
    .out_meta_size     (out_meta_size),
    .out_last          (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // returns how many results one link byte causes, at most two
  function automatic int decode_link_byte(input logic [BYTE_W-1:0] b,
                                          output result_t first, output result_t second);
    result_t r [0:1];
    int      n;
    int      pad;
    n = 0;
    r[0] = '0;
    r[1] = '0;
    case (link_phase)
      LP_COMMAND: begin
        if (b == CMD_UPDATE) begin
          r[n].event_res = EV_ECHO;
          n = n + 1;
          link_phase = LP_VER_LO;
        end else if (b == CMD_BOOT) begin
          r[n].event_res = EV_BOOT;
          n = n + 1;
        end
      end
      LP_VER_LO: begin
        pend_version = {8'h00, b};
        link_phase = LP_VER_HI;
      end
      LP_VER_HI: begin
        pend_version[15:8] = b;
        link_phase = LP_SIZE_LO;
      end
      LP_SIZE_LO: begin
        pend_size = {8'h00, b};
        link_phase = LP_SIZE_HI;
      end
      LP_SIZE_HI: begin
        pend_size[15:8] = b;
        if (pend_version != '0 && pend_version < stored_version_cfg) begin
          r[n].event_res = EV_META_REJ;
          n = n + 1;
          link_phase = LP_COMMAND;
        end else begin
          // version zero means keep what flash already records
          if (pend_version == '0) pend_version = stored_version_cfg;
          r[n].event_res = EV_META_OK;
          r[n].meta_version = pend_version;
          r[n].meta_size = pend_size;
          n = n + 1;
          page_base = image_base_cfg;
          page_fill = 0;
          link_phase = LP_LEN_HI;
        end
      end
      LP_LEN_HI: begin
        frame_size = {b, 8'h00};
        link_phase = LP_LEN_LO;
      end
      LP_LEN_LO: begin
        frame_size[7:0] = b;
        byte_count = 0;
        link_phase = (frame_size != '0) ? LP_DATA : LP_FRAME_TRAIL;
      end
      LP_DATA: begin
        if (page_fill < PAGE_BYTES_DEF) begin
          r[n].event_res = EV_WRITE;
          r[n].flash_address = page_base + ADDR_W'(page_fill);
          r[n].write_byte = b;
          page_fill = page_fill + 1;
        end else begin
          r[n].event_res = EV_DROP;
        end
        n = n + 1;
        byte_count = byte_count + 1;
        if (byte_count >= int'(frame_size)) begin
          byte_count = 0;
          link_phase = LP_FRAME_TRAIL;
        end
      end
      LP_FRAME_TRAIL: begin
        byte_count = byte_count + 1;
        if (byte_count >= TRAILER_BYTES) begin
          byte_count = 0;
          if (page_fill >= PAGE_BYTES_DEF || frame_size == '0) begin
            pad = ((page_fill + WORD_BYTES_DEF - 1) / WORD_BYTES_DEF) * WORD_BYTES_DEF;
            r[n].event_res = EV_COMMIT;
            r[n].flash_address = page_base;
            r[n].page_bytes = CNT_W'(page_fill);
            r[n].padded_bytes = CNT_W'(pad);
            n = n + 1;
            page_base = page_base + ADDR_W'(PAGE_BYTES_DEF);
            page_fill = 0;
          end
          r[n].event_res = EV_ACK;
          n = n + 1;
          link_phase = (frame_size == '0) ? LP_END_TRAIL : LP_LEN_HI;
        end
      end
      LP_END_TRAIL: begin
        byte_count = byte_count + 1;
        if (byte_count >= TRAILER_BYTES) begin
          byte_count = 0;
          link_phase = LP_COMMAND;
        end
      end
      default: link_phase = LP_COMMAND;
    endcase
    if (n > 0) r[n-1].last = 1'b1;
    first = r[0];
    second = r[1];
    return n;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer, event_res %0d", out_event_res);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", 32'(want.event_res), 32'(out_event_res));
        check_field("flash_address", 32'(want.flash_address), 32'(out_flash_address));
        check_field("write_byte", 32'(want.write_byte), 32'(out_write_byte));
        check_field("page_bytes", 32'(want.page_bytes), 32'(out_page_bytes));
        check_field("padded_bytes", 32'(want.padded_bytes), 32'(out_padded_bytes));
        check_field("meta_version", 32'(want.meta_version), 32'(out_meta_version));
        check_field("meta_size", 32'(want.meta_size), 32'(out_meta_size));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  task automatic send_link_byte(input logic [BYTE_W-1:0] b,
                                input row_kind_e kind = ROW_MODEL,
                                input logic [EV_W-1:0] typed_ev = EV_ECHO);
    result_t     first;
    result_t     second;
    link_phase_e prior;
    int          n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    prior = link_phase;
    n = decode_link_byte(b, first, second);
    if (kind == ROW_TYPED) begin
      first = '0;
      first.event_res = typed_ev;
      first.last = 1'b1;
      n = 1;
    end else if (kind == ROW_QUIET) begin
      n = 0;
    end
    if (n > 0) expected_results.push_back(first);
    if (n > 1) expected_results.push_back(second);
    // stray command bytes do not count as stimulus
    if (n > 0 || prior != LP_COMMAND) items_sent++;
  endtask

  // both registers, written only once the block has drained
  task automatic set_config(input logic [VER_W-1:0] ver, input logic [ADDR_W-1:0] base);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_STORED_VERSION;
    cfg_wdata <= CFG_W'(ver);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_BASE;
    cfg_wdata <= CFG_W'(base);
    @(posedge clk);
    cfg_we <= 1'b0;
    stored_version_cfg = ver;
    image_base_cfg = base;
  endtask

  task automatic send_frame(input int len);
    send_link_byte(8'(len >> 8));
    send_link_byte(8'(len));
    repeat (len) send_link_byte(8'($urandom));
    repeat (TRAILER_BYTES) send_link_byte(8'($urandom));
  endtask

  // one update: metadata, then unless rejected the frames of frame_plan, the closing empty frame and the end trailer
  task automatic send_update(input logic [VER_W-1:0] ver);
    logic [VER_W-1:0] image_len;
    image_len = 16'($urandom);
    send_link_byte(CMD_UPDATE);
    send_link_byte(ver[7:0]);
    send_link_byte(ver[15:8]);
    send_link_byte(image_len[7:0]);
    send_link_byte(image_len[15:8]);
    // rejected version, block is back in command wait
    if (link_phase == LP_COMMAND) return;
    foreach (frame_plan[i]) send_frame(frame_plan[i]);
    send_frame(0);
    repeat (TRAILER_BYTES) send_link_byte(8'($urandom));
  endtask

  task automatic random_round();
    logic [VER_W-1:0]  ver;
    logic [BYTE_W-1:0] b;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(2))
        0: ver = 16'h0000;
        1: ver = 16'hFFFF;
        default: ver = 16'($urandom);
      endcase
      set_config(ver, ($urandom_range(2) == 0) ? 18'h3FFF0 : 18'($urandom));
    end
    repeat ($urandom_range(2)) begin
      b = ($urandom_range(2) == 0) ? CMD_BOOT : 8'($urandom);
      if (b == CMD_UPDATE) b = 8'h00;
      send_link_byte(b);
    end
    frame_plan.delete();
    repeat ($urandom_range(3, 1))
      frame_plan.push_back(($urandom_range(9) == 0) ? int'($urandom_range(300, 25))
                                                    : int'($urandom_range(24, 1)));
    if (stored_version_cfg > 16'd1 && $urandom_range(4) == 0)
      ver = 16'($urandom_range(stored_version_cfg - 16'd1, 1));
    else if ($urandom_range(3) == 0)
      ver = 16'h0000;
    else
      ver = 16'($urandom_range(16'hFFFF, stored_version_cfg));
    send_update(ver);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 16;
    recv_stall_pct = 62;
    set_config(16'hFFFF, IMAGE_BASE_RST);
    foreach (directed_rows[i])
      send_link_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].ev);

    // version zero keeps the stored one, image at the bottom of flash
    set_config(16'h0000, 18'h00000);
    frame_plan = '{3};
    send_update(16'h0000);
    // image at the top of flash, byte and page addresses wrap
    set_config(16'hFFFF, 18'h3FFFF);
    frame_plan = '{5, 2};
    send_update(16'h0000);
    frame_plan = '{1};
    send_update(16'hFFFF);
    while (items_sent < ITEM_TARGET / 8) random_round();

    send_idle_pct = 62;
    recv_stall_pct = 16;
    while (items_sent < ITEM_TARGET / 4) random_round();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    // page overflow: extra bytes dropped, full commit, then an empty commit
    set_config(16'h1234, IMAGE_BASE_RST);
    frame_plan = '{1000, 30};
    send_update(16'h1234);
    while (items_sent < ITEM_TARGET) random_round();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
src/fwd_pkg.sv
src/fwd_parse.sv
src/fwd_outq.sv
src/firmware_update_deframer_top.sv
dv/firmware_update_deframer_top_tb.sv
